### src/linear_partition_min_max_defines.svh
// -----------------------------------------------------------------------------
// linear_partition_min_max assertion macros
// Shared concurrent assertion forms for the checker files.
// -----------------------------------------------------------------------------
`ifndef LINEAR_PARTITION_MIN_MAX_DEFINES_SVH
`define LINEAR_PARTITION_MIN_MAX_DEFINES_SVH

// Check a property on every edge outside reset.
`define LPMM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check a property on every edge, reset included.
`define LPMM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### src/lpmm_pkg.sv
// -----------------------------------------------------------------------------
// lpmm_pkg
// Fixed widths and limits shared by the painter's-partition block.
// -----------------------------------------------------------------------------
package lpmm_pkg;

    // Prefix sums and loads are 18 bits and saturate at all ones.
    localparam int SUM_W = 18;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Width of the painters configuration register.
    localparam int PAINTERS_W = 5;

endpackage

### src/linear_partition_min_max.sv
// -----------------------------------------------------------------------------
// linear_partition_min_max
// Painter's partition: minimum over contiguous splits of the largest run sum.
// -----------------------------------------------------------------------------
// Boards load at one per cycle, while s_ready is high, into one of two
// prefix-sum banks. The board marked last closes the set and queues it for
// the partition engine, which evaluates one split point per cycle while
// scanning, through the single read port of the prefix and column RAMs.
// While one set is computed the next one loads into the other bank; outside
// reset, s_ready drops only when both banks hold sets the engine has not
// finished. Boards past MAX_BOARDS are dropped and flagged in m_overflow.
// Write cfg_wr_data (painters) only while the block is idle.
module linear_partition_min_max #(
    parameter int MAX_BOARDS   = 64,
    parameter int MAX_PAINTERS = 16,
    parameter int LENGTH_BITS  = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [LENGTH_BITS-1:0]          s_length,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lpmm_pkg::SUM_W-1:0]      m_best_load,
    output logic                            m_overflow,
    input  logic                            cfg_wr_en,
    input  logic [lpmm_pkg::PAINTERS_W-1:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_BOARDS + 1);
    localparam int JOB_W = 1 + IDX_W + 1 + lpmm_pkg::SUM_W;

    logic [lpmm_pkg::PAINTERS_W-1:0] painters_reg, painters_next;

    logic                       q_push, q_pop, q_empty, q_full;
    logic [JOB_W-1:0]           q_push_data, q_head;
    logic                       pre_wr_en, pre_rd_en;
    logic [IDX_W:0]             pre_wr_addr, pre_rd_addr;
    logic [lpmm_pkg::SUM_W-1:0] pre_wr_data, pre_rd_data;

    // Painters register
    assign painters_next = cfg_wr_en ? cfg_wr_data : painters_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            painters_reg <= lpmm_pkg::PAINTERS_W'(1);
        end else begin
            painters_reg <= painters_next;
        end
    end

    lpmm_front #(
        .MAX_BOARDS  (MAX_BOARDS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_length    (s_length),
        .s_last      (s_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .pre_wr_en   (pre_wr_en),
        .pre_wr_addr (pre_wr_addr),
        .pre_wr_data (pre_wr_data)
    );

    // Two banks of prefix sums, addressed {bank, board}
    lpmm_ram #(
        .WIDTH (lpmm_pkg::SUM_W),
        .DEPTH (2 ** (IDX_W + 1))
    ) u_prefix (
        .aclk    (aclk),
        .wr_en   (pre_wr_en),
        .wr_addr (pre_wr_addr),
        .wr_data (pre_wr_data),
        .rd_en   (pre_rd_en),
        .rd_addr (pre_rd_addr),
        .rd_data (pre_rd_data)
    );

    lpmm_queue #(.WIDTH(JOB_W)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    lpmm_back #(
        .MAX_BOARDS   (MAX_BOARDS),
        .MAX_PAINTERS (MAX_PAINTERS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .painters    (painters_reg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pre_rd_en   (pre_rd_en),
        .pre_rd_addr (pre_rd_addr),
        .pre_rd_data (pre_rd_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_best_load (m_best_load),
        .m_overflow  (m_overflow)
    );

endmodule

### src/lpmm_ram.sv
// -----------------------------------------------------------------------------
// lpmm_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module lpmm_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/lpmm_queue.sv
// -----------------------------------------------------------------------------
// lpmm_queue
// Two-entry job queue between the loader and the partition engine.
// -----------------------------------------------------------------------------
module lpmm_queue #(
    parameter int WIDTH = 27
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign empty     = (count_reg == 2'd0);
    assign full      = count_reg[1];

endmodule

### src/lpmm_front.sv
// -----------------------------------------------------------------------------
// lpmm_front
// Board loader: accepts lengths, builds saturating prefix sums into the
// current bank and queues one job per set when the last board arrives.
// -----------------------------------------------------------------------------
module lpmm_front #(
    parameter int MAX_BOARDS  = 64,
    parameter int LENGTH_BITS = 12,
    localparam int IDX_W = $clog2(MAX_BOARDS + 1),
    localparam int JOB_W = 1 + IDX_W + 1 + lpmm_pkg::SUM_W
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [LENGTH_BITS-1:0]    s_length,
    input  logic                      s_last,
    input  logic                      q_full,
    output logic                      q_push,
    output logic [JOB_W-1:0]          q_push_data,
    output logic                      pre_wr_en,
    output logic [IDX_W:0]            pre_wr_addr,
    output logic [lpmm_pkg::SUM_W-1:0] pre_wr_data
);

    localparam int AW = ((lpmm_pkg::SUM_W > LENGTH_BITS) ? lpmm_pkg::SUM_W : LENGTH_BITS) + 1;

    logic                       bank_reg, bank_next;
    logic [IDX_W-1:0]           count_reg, count_next;
    logic [lpmm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                       ovf_reg, ovf_next;

    logic                       fire;
    logic                       room;
    logic [AW-1:0]              raw_sum;
    logic [lpmm_pkg::SUM_W-1:0] sat_sum;
    logic [IDX_W-1:0]           count_inc;

    // Take a board only when a bank is free for it
    assign s_ready = aresetn && !q_full;
    assign fire    = s_valid && s_ready;
    assign room    = (count_reg < IDX_W'(MAX_BOARDS));

    // Saturating add of the new board onto the running sum
    assign raw_sum   = AW'(sum_reg) + AW'(s_length);
    assign sat_sum   = (raw_sum > AW'(lpmm_pkg::SUM_MAX)) ? lpmm_pkg::SUM_MAX
                                                          : raw_sum[lpmm_pkg::SUM_W-1:0];
    assign count_inc = count_reg + IDX_W'(1);

    assign pre_wr_en   = fire && room;
    assign pre_wr_addr = {bank_reg, count_inc};
    assign pre_wr_data = sat_sum;

    // Update set state; close the set on the last board
    always_comb begin
        bank_next   = bank_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        ovf_next    = ovf_reg;
        q_push      = 1'b0;
        q_push_data = {bank_reg, count_reg, ovf_reg, sum_reg};
        if (fire) begin
            if (room) begin
                count_next = count_inc;
                sum_next   = sat_sum;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_last) begin
                q_push      = 1'b1;
                q_push_data = {bank_reg, count_next, ovf_next, sum_next};
                bank_next   = ~bank_reg;
                count_next  = '0;
                sum_next    = '0;
                ovf_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg  <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            bank_reg  <= bank_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### src/lpmm_back.sv
// -----------------------------------------------------------------------------
// lpmm_back
// Partition engine: runs the painter's DP for the job at the queue head,
// one split point per cycle while scanning, with two ping-pong column RAMs,
// and holds the result in an output register.
// -----------------------------------------------------------------------------
module lpmm_back #(
    parameter int MAX_BOARDS   = 64,
    parameter int MAX_PAINTERS = 16,
    localparam int IDX_W = $clog2(MAX_BOARDS + 1),
    localparam int JOB_W = 1 + IDX_W + 1 + lpmm_pkg::SUM_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lpmm_pkg::PAINTERS_W-1:0] painters,
    input  logic                          q_empty,
    input  logic [JOB_W-1:0]              q_head,
    output logic                          q_pop,
    output logic                          pre_rd_en,
    output logic [IDX_W:0]                pre_rd_addr,
    input  logic [lpmm_pkg::SUM_W-1:0]    pre_rd_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lpmm_pkg::SUM_W-1:0]    m_best_load,
    output logic                          m_overflow
);

    localparam int SW   = lpmm_pkg::SUM_W;
    localparam int P_W  = $clog2(MAX_PAINTERS + 1);
    localparam int KW   = (P_W > lpmm_pkg::PAINTERS_W) ? P_W : lpmm_pkg::PAINTERS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [KW-1:0]    p_reg, p_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] cut_reg, cut_next;
    logic             wsel_reg, wsel_next;
    logic [SW-1:0]    pb_reg, pb_next;
    logic [SW-1:0]    best_reg, best_next;
    logic [SW-1:0]    worst_reg, worst_next;
    logic [SW-1:0]    result_reg, result_next;
    logic             v1_reg, v1_next;
    logic             l1_reg, l1_next;
    logic             v2_reg, v2_next;
    logic             l2_reg, l2_next;
    logic             m_valid_reg, m_valid_next;
    logic [SW-1:0]    m_best_reg, m_best_next;
    logic             m_ovf_reg, m_ovf_next;

    logic             job_bank;
    logic [IDX_W-1:0] job_n;
    logic             job_ovf;
    logic [SW-1:0]    job_total;
    logic [KW-1:0]    painters_ext;
    logic [KW-1:0]    k_eff;

    logic [SW-1:0]    col_a_dout, col_b_dout;
    logic             col_rd_en;
    logic             col_we;
    logic [SW-1:0]    head, tail, cand;

    // Unpack the job at the queue head
    assign job_bank  = q_head[JOB_W-1];
    assign job_n     = q_head[JOB_W-2 -: IDX_W];
    assign job_ovf   = q_head[SW];
    assign job_total = q_head[SW-1:0];

    // Clamp painters into 1..MAX_PAINTERS
    assign painters_ext = KW'(painters);
    always_comb begin
        priority if (painters_ext == '0) begin
            k_eff = KW'(1);
        end else if (painters_ext > KW'(MAX_PAINTERS)) begin
            k_eff = KW'(MAX_PAINTERS);
        end else begin
            k_eff = painters_ext;
        end
    end

    // Prefix reads: row b when fetching, split point during the scan
    assign pre_rd_en   = (state_reg == ST_FETCH) || (state_reg == ST_SCAN);
    assign pre_rd_addr = {job_bank, (state_reg == ST_FETCH) ? b_reg : cut_reg};
    assign col_rd_en   = (state_reg == ST_SCAN);

    // Column A holds even painter counts, column B odd ones
    lpmm_ram #(.WIDTH(SW), .DEPTH(2 ** IDX_W)) u_col_a (
        .aclk    (aclk),
        .wr_en   (col_we && !wsel_reg),
        .wr_addr (b_reg),
        .wr_data (cand),
        .rd_en   (col_rd_en),
        .rd_addr (cut_reg),
        .rd_data (col_a_dout)
    );

    lpmm_ram #(.WIDTH(SW), .DEPTH(2 ** IDX_W)) u_col_b (
        .aclk    (aclk),
        .wr_en   (col_we && wsel_reg),
        .wr_addr (b_reg),
        .wr_data (cand),
        .rd_en   (col_rd_en),
        .rd_addr (cut_reg),
        .rd_data (col_b_dout)
    );

    // Stage 1: worst of head and tail for one split point
    // For two painters the previous column is the prefix sum itself.
    assign head       = (p_reg == KW'(2)) ? pre_rd_data : (wsel_reg ? col_a_dout : col_b_dout);
    assign tail       = pb_reg - pre_rd_data;
    assign worst_next = (head > tail) ? head : tail;

    // Stage 2: running minimum
    assign cand = (worst_reg < best_reg) ? worst_reg : best_reg;

    // Sequencer over painters, boards and split points
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        b_next       = b_reg;
        cut_next     = cut_reg;
        wsel_next    = wsel_reg;
        pb_next      = pb_reg;
        best_next    = v2_reg ? cand : best_reg;
        result_next  = result_reg;
        v1_next      = (state_reg == ST_SCAN);
        l1_next      = (state_reg == ST_SCAN) && (cut_reg == b_reg);
        v2_next      = v1_reg;
        l2_next      = l1_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_best_next  = m_best_reg;
        m_ovf_next   = m_ovf_reg;
        col_we       = 1'b0;
        q_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    k_next    = k_eff;
                    p_next    = KW'(2);
                    b_next    = IDX_W'(1);
                    wsel_next = 1'b0;
                    if (k_eff == KW'(1) || job_n == '0) begin
                        result_next = job_total;
                        state_next  = ST_FINISH;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                pb_next    = pre_rd_data;
                cut_next   = IDX_W'(1);
                best_next  = lpmm_pkg::SUM_MAX;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cut_next = cut_reg + IDX_W'(1);
                if (cut_reg == b_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (v2_reg && l2_reg) begin
                    col_we      = 1'b1;
                    result_next = cand;
                    if (b_reg == job_n) begin
                        if (p_reg == k_reg) begin
                            state_next = ST_FINISH;
                        end else begin
                            p_next     = p_reg + KW'(1);
                            wsel_next  = ~wsel_reg;
                            b_next     = IDX_W'(1);
                            state_next = ST_FETCH;
                        end
                    end else begin
                        b_next     = b_reg + IDX_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_best_next  = result_reg;
                    m_ovf_next   = job_ovf;
                    q_pop        = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        p_reg      <= p_next;
        b_reg      <= b_next;
        cut_reg    <= cut_next;
        wsel_reg   <= wsel_next;
        pb_reg     <= pb_next;
        best_reg   <= best_next;
        worst_reg  <= worst_next;
        result_reg <= result_next;
        l1_reg     <= l1_next;
        l2_reg     <= l2_next;
        m_best_reg <= m_best_next;
        m_ovf_reg  <= m_ovf_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_best_load = m_best_reg;
    assign m_overflow  = m_ovf_reg;

endmodule

### src/lpmm_checker.sv
// -----------------------------------------------------------------------------
// lpmm_checker
// Port-level checks on the painter's-partition block, bound to the top level.
// -----------------------------------------------------------------------------
`include "linear_partition_min_max_defines.svh"

module lpmm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [lpmm_pkg::SUM_W-1:0] m_best_load,
    input logic                       m_overflow
);

    // A stalled result transfer keeps its payload
    `LPMM_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_best_load) && $stable(m_overflow), "result changed while stalled")

    // Reset drops any pending result
    `LPMM_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // Both banks are free after reset, so the loader is open
    `LPMM_ASSERT_ALWAYS(a_reset_opens_in, aclk, !aresetn |=> s_ready || !aresetn, "input closed after reset")

    // No board is taken while reset is held
    `LPMM_ASSERT_ALWAYS(a_no_accept_in_reset, aclk, !aresetn |-> !(s_valid && s_ready), "input transfer during reset")

endmodule

bind linear_partition_min_max lpmm_checker u_lpmm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_best_load (m_best_load),
    .m_overflow  (m_overflow)
);
